>>> src/ssalu_pkg.sv
`timescale 1ns / 1ps
package ssalu_pkg;
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIV_ZERO = 3'd1,
        ST_DIV_INV  = 3'd2,
        ST_DIV_FUT  = 3'd3,
        ST_DIV_PAST = 3'd4,
        ST_MOD_SENT = 3'd5,
        ST_INVALID  = 3'd6
    } t_status;

    // result selection decided up front, carried down the cell row
    typedef enum logic [2:0] {
        SEL_FIXED = 3'd0,
        SEL_SUM   = 3'd1,
        SEL_PROD  = 3'd2,
        SEL_QUOT  = 3'd3,
        SEL_REM   = 3'd4
    } t_sel;

    typedef struct packed {
        logic    valid;
        t_sel    sel;
        t_status status;
        logic    neg_q;
        logic    neg_a;
        logic    neg_b;
        logic    zero_a;
    } t_ctrl;
endpackage

>>> src/ssalu_cell.sv
`timescale 1ns / 1ps
// One restoring divide step per cell: divisor, remainder and quotient shift along.
module ssalu_cell
    import ssalu_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_ctrl        i_ctrl,
    input  logic [W-1:0] i_dvd,
    input  logic [W-1:0] i_dvs,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_fix,
    input  logic [W-1:0] i_sum,
    input  logic [2*W-1:0] i_prod,
    output t_ctrl        o_ctrl,
    output logic [W-1:0] o_dvd,
    output logic [W-1:0] o_dvs,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_fix,
    output logic [W-1:0] o_sum,
    output logic [2*W-1:0] o_prod
);
    t_ctrl          r_ctrl;
    logic [W-1:0]   r_dvd, r_dvs, r_rem, r_quo, r_fix, r_sum;
    logic [2*W-1:0] r_prod;
    logic [W:0]     w_trial;
    logic [W:0]     w_diff;

    assign w_trial = {i_rem, i_dvd[W-1]};
    assign w_diff  = w_trial - {1'b0, i_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd  <= {i_dvd[W-2:0], 1'b0};
            r_dvs  <= i_dvs;
            r_fix  <= i_fix;
            r_sum  <= i_sum;
            r_prod <= i_prod;
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {i_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {i_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_dvd  = r_dvd;
    assign o_dvs  = r_dvs;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_fix  = r_fix;
    assign o_sum  = r_sum;
    assign o_prod = r_prod;
endmodule

>>> src/ssalu_front.sv
`timescale 1ns / 1ps
// Sentinel decode, saturating add, magnitudes and multiply (registered).
module ssalu_front
    import ssalu_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [2:0]   i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_ctrl        o_ctrl,
    output logic [W-1:0] o_ma,
    output logic [W-1:0] o_mb,
    output logic [W-1:0] o_fix,
    output logic [W-1:0] o_sum,
    output logic [2*W-1:0] o_prod
);
    localparam logic [W-1:0] VINV  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] VPAST = {1'b1, {(W-2){1'b0}}, 1'b1};
    localparam logic [W-1:0] VFUT  = {1'b0, {(W-1){1'b1}}};

    t_ctrl          n_ctrl, r_ctrl;
    logic [W-1:0]   n_fix, r_fix, r_sum, n_sum, r_ma, r_mb, w_ma, w_mb, w_bb;
    logic [2*W-1:0] r_prod;
    logic [W:0]     w_s;
    logic           a_inv, a_pst, a_fut, b_inv, b_pst, b_fut, bb_pst, bb_fut, bb_inv;
    logic           sent_hit;
    logic [W-1:0]   sent_val;

    assign a_inv = i_a == VINV;
    assign a_pst = i_a == VPAST;
    assign a_fut = i_a == VFUT;
    assign b_inv = i_b == VINV;
    assign b_pst = i_b == VPAST;
    assign b_fut = i_b == VFUT;
    assign w_bb  = (i_op == OP_SUB && !b_inv) ? (~i_b + 1'b1) : i_b;
    assign bb_inv = w_bb == VINV;
    assign bb_pst = w_bb == VPAST;
    assign bb_fut = w_bb == VFUT;
    assign w_ma  = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb  = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_s   = {i_a[W-1], i_a} + {w_bb[W-1], w_bb};

    always_comb begin
        sent_hit = 1'b1;
        sent_val = VFUT;
        if (a_inv || bb_inv) sent_val = VINV;
        else if (a_pst || bb_pst) sent_val = (a_fut || bb_fut) ? VINV : VPAST;
        else if (!(a_fut || bb_fut)) sent_hit = 1'b0;
        // add result: saturate at past/future
        if ($signed(w_s) >= $signed({1'b0, VFUT})) n_sum = VFUT;
        else if ($signed(w_s) <= $signed({1'b1, VPAST})) n_sum = VPAST;
        else n_sum = w_s[W-1:0];
        if (sent_hit) n_sum = sent_val;
    end

    always_comb begin
        n_ctrl        = '0;
        n_ctrl.valid  = i_valid;
        n_ctrl.neg_a  = i_a[W-1];
        n_ctrl.neg_b  = i_b[W-1];
        n_ctrl.neg_q  = i_a[W-1] ^ i_b[W-1];
        n_ctrl.zero_a = i_a == '0;
        n_ctrl.sel    = SEL_FIXED;
        n_ctrl.status = ST_OK;
        n_fix         = '0;
        unique case (i_op)
            OP_ADD, OP_SUB: n_ctrl.sel = SEL_SUM;
            OP_MUL: begin
                if (a_inv || b_inv || ((a_pst || b_pst) && (a_fut || b_fut)))
                    n_ctrl.status = ST_INVALID;
                else if (a_pst || b_pst) n_fix = VPAST;
                else if (a_fut || b_fut) n_fix = VFUT;
                else n_ctrl.sel = SEL_PROD;
            end
            OP_DIV: begin
                if (i_b == '0) n_ctrl.status = ST_DIV_ZERO;
                else if (b_inv) n_ctrl.status = ST_DIV_INV;
                else if (b_fut) n_ctrl.status = ST_DIV_FUT;
                else if (b_pst) n_ctrl.status = ST_DIV_PAST;
                else if (a_inv) n_ctrl.status = ST_INVALID;
                else if (a_pst) n_fix = VPAST;
                else if (a_fut) n_fix = VFUT;
                else n_ctrl.sel = SEL_QUOT;
            end
            OP_MOD: begin
                if (i_b == '0) n_ctrl.status = ST_DIV_ZERO;
                else if (a_inv || a_pst || a_fut || b_inv || b_pst || b_fut)
                    n_ctrl.status = ST_MOD_SENT;
                else n_ctrl.sel = SEL_REM;
            end
            default: n_ctrl.status = ST_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fix  <= n_fix;
            r_sum  <= n_sum;
            r_ma   <= w_ma;
            r_mb   <= w_mb;
            r_prod <= w_ma * w_mb;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_ma   = r_ma;
    assign o_mb   = r_mb;
    assign o_fix  = r_fix;
    assign o_sum  = r_sum;
    assign o_prod = r_prod;
endmodule

>>> src/ssalu_back.sv
`timescale 1ns / 1ps
// Sign fixup, Euclidean correction, multiply saturation, output register.
module ssalu_back
    import ssalu_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_ctrl        i_ctrl,
    input  logic [W-1:0] i_mb,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_fix,
    input  logic [W-1:0] i_sum,
    input  logic [2*W-1:0] i_prod,
    output logic         o_valid,
    output logic [W-1:0] o_value,
    output logic [2:0]   o_status
);
    localparam logic [W-1:0] VPAST = {1'b1, {(W-2){1'b0}}, 1'b1};
    localparam logic [W-1:0] VFUT  = {1'b0, {(W-1){1'b1}}};

    logic         r_valid;
    logic [W-1:0] r_value, n_value, w_q, w_r, w_p;
    logic [2:0]   r_status;
    logic         w_rnz;

    // magnitude quotient/remainder -> truncated signed, then Euclidean
    assign w_rnz = i_rem != '0;
    always_comb begin
        w_q = i_ctrl.neg_q ? (~i_quo + 1'b1) : i_quo;
        w_r = i_rem;
        if (i_ctrl.neg_a && w_rnz) begin
            w_r = i_mb - i_rem;
            w_q = i_ctrl.neg_b ? (w_q + 1'b1) : (w_q - 1'b1);
        end
        if (i_prod >= {{W{1'b0}}, VFUT})
            w_p = i_ctrl.neg_q ? VPAST : VFUT;
        else
            w_p = i_ctrl.neg_q ? (~i_prod[W-1:0] + 1'b1) : i_prod[W-1:0];
        case (i_ctrl.sel)
            SEL_SUM:  n_value = i_sum;
            SEL_PROD: n_value = w_p;
            SEL_QUOT: n_value = w_q;
            SEL_REM:  n_value = w_r;
            default:  n_value = i_fix;
        endcase
        if (i_ctrl.status != ST_OK) n_value = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value  <= n_value;
            r_status <= i_ctrl.status;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;
endmodule

>>> src/sentinel_saturating_alu.sv
`timescale 1ns / 1ps
// Sentinel-aware saturating signed ALU.
// Channels: input transaction (i_valid/o_ready) carries i_operation,
// i_left_operand, i_right_operand; output transaction (o_valid/i_ready)
// carries o_result_value and o_status.
// Pipeline: front stage, one divide cell per result bit, back stage;
// one transaction per cycle while the receiver does not stall.
// The pipeline depth is set by the row of restoring divide cells, one
// quotient bit each; every operation travels the same row so order holds.
// Reset clears all valid bits; the pipe empties, payload is don't-care.
// When the receiver stalls with a result waiting, the whole pipe holds and
// o_ready falls; a new input is taken whenever the output register is
// empty or being read in the same cycle.
module sentinel_saturating_alu
    import ssalu_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0]             i_operation,
    input  logic [VALUE_WIDTH-1:0] i_left_operand,
    input  logic [VALUE_WIDTH-1:0] i_right_operand,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_result_value,
    output logic [2:0]             o_status
);
    localparam int W = VALUE_WIDTH;

    logic               w_en;
    t_ctrl              c_ctrl [W+1];
    logic [W-1:0]       c_dvd  [W+1];
    logic [W-1:0]       c_dvs  [W+1];
    logic [W-1:0]       c_rem  [W+1];
    logic [W-1:0]       c_quo  [W+1];
    logic [W-1:0]       c_fix  [W+1];
    logic [W-1:0]       c_sum  [W+1];
    logic [2*W-1:0]     c_prod [W+1];

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    ssalu_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_op    (i_operation),
        .i_a     (i_left_operand),
        .i_b     (i_right_operand),
        .o_ctrl  (c_ctrl[0]),
        .o_ma    (c_dvd[0]),
        .o_mb    (c_dvs[0]),
        .o_fix   (c_fix[0]),
        .o_sum   (c_sum[0]),
        .o_prod  (c_prod[0])
    );
    assign c_rem[0] = '0;
    assign c_quo[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        ssalu_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (c_ctrl[g]),
            .i_dvd   (c_dvd[g]),
            .i_dvs   (c_dvs[g]),
            .i_rem   (c_rem[g]),
            .i_quo   (c_quo[g]),
            .i_fix   (c_fix[g]),
            .i_sum   (c_sum[g]),
            .i_prod  (c_prod[g]),
            .o_ctrl  (c_ctrl[g+1]),
            .o_dvd   (c_dvd[g+1]),
            .o_dvs   (c_dvs[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_quo   (c_quo[g+1]),
            .o_fix   (c_fix[g+1]),
            .o_sum   (c_sum[g+1]),
            .o_prod  (c_prod[g+1])
        );
    end

    ssalu_back #(.W(W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctrl   (c_ctrl[W]),
        .i_mb     (c_dvs[W]),
        .i_rem    (c_rem[W]),
        .i_quo    (c_quo[W]),
        .i_fix    (c_fix[W]),
        .i_sum    (c_sum[W]),
        .i_prod   (c_prod[W]),
        .o_valid  (o_valid),
        .o_value  (o_result_value),
        .o_status (o_status)
    );
endmodule

>>> src/ssalu_checker.sv
`timescale 1ns / 1ps
module ssalu_checker
    import ssalu_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [VALUE_WIDTH-1:0] o_result_value,
    input logic [2:0]             o_status
);
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_result_value == '0)
        else $error("nonzero value with error status");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_INVALID)
        else $error("status out of range");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("stalled output changed");
endmodule

bind sentinel_saturating_alu ssalu_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_ssalu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_value (o_result_value),
    .o_status       (o_status)
);
